// ===== design/pds_pkg.sv =====
package pds_pkg;

  localparam int OSC_W   = 15;
  localparam int TGT_W   = 17;
  localparam int FIELD_W = 5;
  localparam int HZ_W    = 28;

  localparam int PREDIV_MAX = 25;
  localparam int MULT_MIN   = 24;
  localparam int MULT_MAX   = 55;

  localparam int REF_MIN_KHZ = 2000;
  localparam int REF_MAX_KHZ = 4000;
  localparam int HZ_PER_KHZ  = 1000;

  localparam int DIV_W  = $clog2(PREDIV_MAX + 1);
  localparam int MULT_W = $clog2(MULT_MAX + 1);
  localparam int PROD_W = OSC_W + MULT_W;
  localparam int KHZ_W  = $clog2(HZ_PER_KHZ + 1);
  localparam int NUM_W  = PROD_W + KHZ_W;
  localparam int CNT_W  = $clog2(NUM_W);

endpackage

// ===== design/pds_in_if.sv =====
interface pds_in_if;
  logic                     valid;
  logic                     ready;
  logic [pds_pkg::OSC_W-1:0] osc_khz;
  logic [pds_pkg::TGT_W-1:0] target_khz;

  modport source (output valid, output osc_khz, output target_khz, input ready);
  modport sink (input valid, input osc_khz, input target_khz, output ready);
endinterface

// ===== design/pds_out_if.sv =====
interface pds_out_if;
  logic                       valid;
  logic                       ready;
  logic [pds_pkg::FIELD_W-1:0] prediv_field;
  logic [pds_pkg::FIELD_W-1:0] mult_field;
  logic [pds_pkg::HZ_W-1:0]    achieved_hz;
  logic                       found;

  modport source (output valid, output prediv_field, output mult_field,
                  output achieved_hz, output found, input ready);
  modport sink (input valid, input prediv_field, input mult_field,
                input achieved_hz, input found, output ready);
endinterface

// ===== design/pds_serdiv.sv =====
// Restoring divider, one quotient bit per cycle, MSB first.
module pds_serdiv (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pds_pkg::NUM_W-1:0]   num,
  input  logic [pds_pkg::DIV_W-1:0]   den,
  output logic                        done,
  output logic [pds_pkg::NUM_W-1:0]   quot,
  output logic [pds_pkg::DIV_W-1:0]   rem
);

  logic [pds_pkg::NUM_W-1:0] num_sh;
  logic [pds_pkg::DIV_W-1:0] den_r;
  logic [pds_pkg::CNT_W-1:0] cnt;
  logic                      busy;
  logic [pds_pkg::DIV_W:0]   trial;
  logic                      qbit;
  logic [pds_pkg::DIV_W:0]   diff;

  always_comb begin
    trial = {rem, num_sh[pds_pkg::NUM_W-1]};
    qbit  = (trial >= {1'b0, den_r});
    diff  = trial - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        num_sh <= num;
        den_r  <= den;
        rem    <= '0;
        cnt    <= '0;
        busy   <= 1'b1;
      end else if (busy) begin
        rem    <= qbit ? diff[pds_pkg::DIV_W-1:0] : trial[pds_pkg::DIV_W-1:0];
        quot   <= {quot[pds_pkg::NUM_W-2:0], qbit};
        num_sh <= {num_sh[pds_pkg::NUM_W-2:0], 1'b0};
        cnt    <= cnt + 1'b1;
        if (cnt == pds_pkg::CNT_W'(pds_pkg::NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/pll_divider_search.sv =====
// Picks the PLL pre-divider (1..25) and multiplier (24..55) whose clock
// floor(osc*mult/div) kHz lands closest to the target, using only pre-dividers
// whose reference floor(osc/div) sits in 2000..4000 kHz; ties keep the first
// pair met with the pre-divider ascending outside and the multiplier inside.
// One item is in work at a time, and a new beat is refused while a result waits.
// A bit-serial divider (a load, then 31 quotient bits) sets the pace. Every
// pre-divider takes one division for its reference plus a step in S_NEXT; a
// valid one adds a division for the first multiplier and a step per multiplier
// in S_SCAN. An oscillator of 32000..32007 kHz has nine valid pre-dividers.
// When a pair is found, out valid rises after a last division for achieved_hz;
// with no valid pre-divider, found is 0 and the other fields are 0.
module pll_divider_search (
  input logic             clk,
  input logic             rst,
  pds_in_if.sink          in_ch,
  pds_out_if.source       out_ch
);

  typedef enum logic [3:0] {
    S_IDLE, S_REF, S_BASE, S_SCAN, S_NEXT, S_FMUL, S_FNUM, S_FDIV, S_OUT
  } state_t;

  state_t state;

  logic [pds_pkg::OSC_W-1:0]  osc;
  logic [pds_pkg::TGT_W-1:0]  tgt;
  logic [pds_pkg::DIV_W-1:0]  div;
  logic [pds_pkg::MULT_W-1:0] mult;
  logic [pds_pkg::OSC_W-1:0]  qo;
  logic [pds_pkg::DIV_W-1:0]  ro;
  logic [pds_pkg::PROD_W-1:0] q;
  logic [pds_pkg::DIV_W-1:0]  r;
  logic                       have;
  logic [pds_pkg::PROD_W-1:0] best_diff;
  logic [pds_pkg::DIV_W-1:0]  chosen_div;
  logic [pds_pkg::MULT_W-1:0] best_mult;
  logic [pds_pkg::PROD_W-1:0] prod;

  logic [pds_pkg::FIELD_W-1:0] res_prediv;
  logic [pds_pkg::FIELD_W-1:0] res_mult;
  logic [pds_pkg::HZ_W-1:0]    res_hz;
  logic                        res_found;

  logic                       dv_start;
  logic [pds_pkg::NUM_W-1:0]  dv_num;
  logic [pds_pkg::DIV_W-1:0]  dv_den;
  logic                       dv_done;
  logic [pds_pkg::NUM_W-1:0]  dv_quot;
  logic [pds_pkg::DIV_W-1:0]  dv_rem;

  logic [pds_pkg::PROD_W-1:0] tgt_ext;
  logic [pds_pkg::PROD_W-1:0] diff;
  logic [pds_pkg::DIV_W:0]    rsum;
  logic                       wrap;
  logic                       ref_ok;

  pds_serdiv u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .done  (dv_done),
    .quot  (dv_quot),
    .rem   (dv_rem)
  );

  always_comb begin
    tgt_ext = pds_pkg::PROD_W'(tgt);
    diff    = (q >= tgt_ext) ? (q - tgt_ext) : (tgt_ext - q);
    rsum    = {1'b0, r} + {1'b0, ro};
    wrap    = (rsum >= {1'b0, div});
    ref_ok  = (dv_quot >= pds_pkg::NUM_W'(pds_pkg::REF_MIN_KHZ)) &&
              (dv_quot <= pds_pkg::NUM_W'(pds_pkg::REF_MAX_KHZ));
  end

  // hold off new beats until the last result has left
  assign in_ch.ready         = (state == S_IDLE) && !out_ch.valid;
  assign out_ch.prediv_field = res_prediv;
  assign out_ch.mult_field   = res_mult;
  assign out_ch.achieved_hz  = res_hz;
  assign out_ch.found        = res_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_ch.valid <= 1'b0;
      dv_start     <= 1'b0;
      have         <= 1'b0;
    end else begin
      dv_start <= 1'b0;
      if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            osc      <= in_ch.osc_khz;
            tgt      <= in_ch.target_khz;
            div      <= pds_pkg::DIV_W'(1);
            have     <= 1'b0;
            dv_start <= 1'b1;
            dv_num   <= pds_pkg::NUM_W'(in_ch.osc_khz);
            dv_den   <= pds_pkg::DIV_W'(1);
            state    <= S_REF;
          end
        end
        S_REF: begin
          if (dv_done) begin
            qo <= dv_quot[pds_pkg::OSC_W-1:0];
            ro <= dv_rem;
            if (ref_ok) begin
              dv_start <= 1'b1;
              dv_num   <= pds_pkg::NUM_W'(osc * pds_pkg::MULT_MIN);
              dv_den   <= div;
              state    <= S_BASE;
            end else begin
              state <= S_NEXT;
            end
          end
        end
        S_BASE: begin
          if (dv_done) begin
            q     <= dv_quot[pds_pkg::PROD_W-1:0];
            r     <= dv_rem;
            mult  <= pds_pkg::MULT_W'(pds_pkg::MULT_MIN);
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!have || diff < best_diff) begin
            have       <= 1'b1;
            best_diff  <= diff;
            chosen_div <= div;
            best_mult  <= mult;
          end
          // step to the next multiplier: add osc/div as quotient plus remainder
          q    <= q + pds_pkg::PROD_W'(qo) + pds_pkg::PROD_W'(wrap);
          r    <= wrap ? pds_pkg::DIV_W'(rsum - {1'b0, div}) : rsum[pds_pkg::DIV_W-1:0];
          mult <= mult + 1'b1;
          if (mult == pds_pkg::MULT_W'(pds_pkg::MULT_MAX)) begin
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (div == pds_pkg::DIV_W'(pds_pkg::PREDIV_MAX)) begin
            state <= S_FMUL;
          end else begin
            div      <= div + 1'b1;
            dv_start <= 1'b1;
            dv_num   <= pds_pkg::NUM_W'(osc);
            dv_den   <= div + 1'b1;
            state    <= S_REF;
          end
        end
        S_FMUL: begin
          if (have) begin
            prod  <= pds_pkg::PROD_W'(osc) * pds_pkg::PROD_W'(best_mult);
            state <= S_FNUM;
          end else begin
            res_prediv <= '0;
            res_mult   <= '0;
            res_hz     <= '0;
            res_found  <= 1'b0;
            state      <= S_OUT;
          end
        end
        S_FNUM: begin
          dv_start <= 1'b1;
          dv_num   <= pds_pkg::NUM_W'(prod * pds_pkg::HZ_PER_KHZ);
          dv_den   <= chosen_div;
          state    <= S_FDIV;
        end
        S_FDIV: begin
          if (dv_done) begin
            res_prediv <= pds_pkg::FIELD_W'(chosen_div - 1'b1);
            res_mult   <= pds_pkg::FIELD_W'(best_mult -
                                            pds_pkg::MULT_W'(pds_pkg::MULT_MIN));
            res_hz     <= dv_quot[pds_pkg::HZ_W-1:0];
            res_found  <= 1'b1;
            state      <= S_OUT;
          end
        end
        S_OUT: begin
          out_ch.valid <= 1'b1;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/pds_check.sv =====
module pds_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic [pds_pkg::FIELD_W-1:0] prediv_field,
  input logic [pds_pkg::FIELD_W-1:0] mult_field,
  input logic [pds_pkg::HZ_W-1:0]    achieved_hz,
  input logic                        found
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input still ready after accepting a beat");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> prediv_field == '0 && mult_field == '0 && achieved_hz == '0)
    else $error("fields not cleared with found low");

  a_prediv_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> prediv_field <= pds_pkg::FIELD_W'(pds_pkg::PREDIV_MAX - 1))
    else $error("pre-divider field out of range");

  a_mult_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |->
      mult_field <= pds_pkg::FIELD_W'(pds_pkg::MULT_MAX - pds_pkg::MULT_MIN))
    else $error("multiplier field out of range");

endmodule

bind pll_divider_search pds_check u_pds_check (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .prediv_field (out_ch.prediv_field),
  .mult_field   (out_ch.mult_field),
  .achieved_hz  (out_ch.achieved_hz),
  .found        (out_ch.found)
);

// ===== tb/tb.sv =====
module tb;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned SETTLE_CYCLES = 3000;
  localparam int unsigned RANDOM_ITEMS = 120;
  localparam int unsigned SHOW_MAX = 10;

  typedef struct packed {
    logic [pds_pkg::FIELD_W-1:0] prediv_field;
    logic [pds_pkg::FIELD_W-1:0] mult_field;
    logic [pds_pkg::HZ_W-1:0]    achieved_hz;
    logic                        found;
  } pll_pick_t;

  class divider_ledger;
    pll_pick_t   pending_picks[$];
    int unsigned n_checked;
    int unsigned n_found;
    int unsigned n_none;
    int unsigned n_bad;

    // Full search over every pre-divider and multiplier; strict < keeps the first tie.
    function pll_pick_t closest_pair(logic [pds_pkg::OSC_W-1:0] osc,
                                     logic [pds_pkg::TGT_W-1:0] tgt);
      pll_pick_t       pick;
      longint unsigned osc_l, tgt_l, ref_k, clk_k, gap, best_gap, hz;
      int              chosen_div, best_mult;
      bit              have;
      pick = '0;
      osc_l = osc;
      tgt_l = tgt;
      have = 1'b0;
      best_gap = 0;
      chosen_div = 0;
      best_mult = 0;
      for (int d = 1; d <= pds_pkg::PREDIV_MAX; d++) begin
        ref_k = osc_l / d;
        if (ref_k < pds_pkg::REF_MIN_KHZ || ref_k > pds_pkg::REF_MAX_KHZ) continue;
        for (int m = pds_pkg::MULT_MIN; m <= pds_pkg::MULT_MAX; m++) begin
          clk_k = osc_l * m / d;
          gap = (clk_k >= tgt_l) ? clk_k - tgt_l : tgt_l - clk_k;
          if (!have || gap < best_gap) begin
            have = 1'b1;
            best_gap = gap;
            chosen_div = d;
            best_mult = m;
          end
        end
      end
      if (have) begin
        hz = osc_l * pds_pkg::HZ_PER_KHZ * best_mult / chosen_div;
        pick.prediv_field = pds_pkg::FIELD_W'(chosen_div - 1);
        pick.mult_field = pds_pkg::FIELD_W'(best_mult - pds_pkg::MULT_MIN);
        pick.achieved_hz = pds_pkg::HZ_W'(hz);
        pick.found = 1'b1;
      end
      return pick;
    endfunction

    function void note_input(logic [pds_pkg::OSC_W-1:0] osc,
                             logic [pds_pkg::TGT_W-1:0] tgt);
      pending_picks.push_back(closest_pair(osc, tgt));
    endfunction

    function void check_result(pll_pick_t got);
      pll_pick_t want;
      if (pending_picks.size() == 0) begin
        n_bad++;
        if (n_bad <= SHOW_MAX)
          $display("result beat with nothing pending: prediv %0d mult %0d hz %0d found %0b",
                   got.prediv_field, got.mult_field, got.achieved_hz, got.found);
        return;
      end
      want = pending_picks.pop_front();
      n_checked++;
      if (want.found) n_found++;
      else n_none++;
      if (got.prediv_field !== want.prediv_field || got.mult_field !== want.mult_field ||
          got.achieved_hz !== want.achieved_hz || got.found !== want.found) begin
        n_bad++;
        if (n_bad <= SHOW_MAX)
          $display("mismatch: want prediv %0d mult %0d hz %0d found %0b, got %0d %0d %0d %0b",
                   want.prediv_field, want.mult_field, want.achieved_hz, want.found,
                   got.prediv_field, got.mult_field, got.achieved_hz, got.found);
      end
    endfunction

    function int unsigned pending();
      return pending_picks.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int unsigned cycle_cnt = 0;
  int unsigned burst_left = 0;
  divider_ledger ledger = new();

  pds_in_if  in_ch();
  pds_out_if out_ch();

  pll_divider_search u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_cnt,
               ledger.pending());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      ledger.check_result({out_ch.prediv_field, out_ch.mult_field, out_ch.achieved_hz,
                           out_ch.found});
  end

  // Receiver: rotate a stall mask, reload it after every result beat.
  initial begin
    logic [7:0] stall_mask;
    stall_mask = 8'hFF;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if ($urandom_range(0, 2) == 0) stall_mask = 8'hFF;
        else stall_mask = 8'($urandom);
        if (stall_mask == 8'h00) stall_mask = 8'h01;
      end else begin
        stall_mask = {stall_mask[0], stall_mask[7:1]};
      end
      out_ch.ready <= !rst && stall_mask[0];
    end
  end

  task automatic send_beat(input logic [pds_pkg::OSC_W-1:0] osc,
                           input logic [pds_pkg::TGT_W-1:0] tgt);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 6);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.osc_khz <= osc;
    in_ch.target_khz <= tgt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ledger.note_input(osc, tgt);
  endtask

  // Hold the sender until every pending result has come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (ledger.pending() != 0);
  endtask

  initial begin
    int                        sel, d, m, near;
    logic [pds_pkg::OSC_W-1:0] osc;
    logic [pds_pkg::TGT_W-1:0] tgt;
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.osc_khz <= '0;
    in_ch.target_khz <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no usable pre-divider
    send_beat(15'd0, 17'd0);
    send_beat(15'd1, 17'd1);
    send_beat(15'd1999, 17'd50000);
    send_beat(15'd100, 17'd131071);
    // reference right on the window edges; target 0 is closest on the first pair
    send_beat(15'd2000, 17'd0);
    send_beat(15'd4000, 17'd131071);
    send_beat(15'd4001, 17'd100000);
    send_beat(15'd2001, 17'd48000);
    // exact hits at the lowest and highest multiplier
    send_beat(15'd3000, 17'd72000);
    send_beat(15'd3000, 17'd165000);
    // exact hit reachable from two pre-dividers, then a tie between them
    send_beat(15'd6000, 17'd96000);
    send_beat(15'd6000, 17'd97000);
    // field extremes and bit patterns
    send_beat(15'd32767, 17'd131071);
    send_beat(15'd32767, 17'd0);
    send_beat(15'd21845, 17'd87381);
    send_beat(15'd10922, 17'd43690);
    send_beat(15'd16384, 17'd65536);
    send_beat(15'd8191, 17'd16383);
    send_beat(15'd12345, 17'd54321);
    send_beat(15'd25000, 17'd99999);
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) wait_drained();
      sel = $urandom_range(0, 19);
      if (sel < 2) begin
        osc = pds_pkg::OSC_W'($urandom_range(0, pds_pkg::REF_MIN_KHZ - 1));
        tgt = pds_pkg::TGT_W'($urandom_range(0, (1 << pds_pkg::TGT_W) - 1));
      end else if (sel < 3) begin
        osc = pds_pkg::OSC_W'($urandom);
        tgt = pds_pkg::TGT_W'($urandom);
      end else begin
        osc = pds_pkg::OSC_W'($urandom_range(pds_pkg::REF_MIN_KHZ,
                                             (1 << pds_pkg::OSC_W) - 1));
        tgt = pds_pkg::TGT_W'($urandom_range(0, (1 << pds_pkg::TGT_W) - 1));
        // aim near a reachable clock most of the time
        if (sel < 14) begin
          d = $urandom_range(1, pds_pkg::PREDIV_MAX);
          m = $urandom_range(pds_pkg::MULT_MIN, pds_pkg::MULT_MAX);
          near = int'(osc) * m / d + int'($urandom_range(0, 64)) - 32;
          if (near >= 0 && near < (1 << pds_pkg::TGT_W)) tgt = pds_pkg::TGT_W'(near);
        end
      end
      send_beat(osc, tgt);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("checked %0d searches: %0d found a divider pair, %0d had none",
             ledger.n_checked, ledger.n_found, ledger.n_none);
    $display("%0d mismatching beats, %0d cycles", ledger.n_bad, cycle_cnt);
    if (ledger.n_bad == 0 && ledger.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== pll_divider_search.f =====
design/pds_pkg.sv
design/pds_in_if.sv
design/pds_out_if.sv
design/pds_serdiv.sv
design/pll_divider_search.sv
design/pds_check.sv
tb/tb.sv
